>>> rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared definitions for the Playfair digraph cipher
// Op codes, letter codes, square size and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // item ops
  localparam logic [2:0] OP_KEY_START  = 3'd0;
  localparam logic [2:0] OP_KEY_LETTER = 3'd1;
  localparam logic [2:0] OP_KEY_FINISH = 3'd2;
  localparam logic [2:0] OP_ENCRYPT    = 3'd3;
  localparam logic [2:0] OP_DECRYPT    = 3'd4;

  // letter codes, A=0 .. Z=25
  localparam logic [4:0] CODE_I = 5'd8;
  localparam logic [4:0] CODE_J = 5'd9;
  localparam logic [4:0] CODE_X = 5'd23;
  localparam logic [4:0] CODE_Y = 5'd24;
  localparam logic [4:0] CODE_Z = 5'd25;

  localparam int CELLS   = 25;
  localparam int LETTERS = 26;
  localparam logic [4:0] SQUARE_FULL = 5'd25;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic clear_key;
    logic place_item;
    logic fill_start;
    logic fill_step;
    logic plan;
    logic read_pos;
    logic read_cell;
    logic emit_first;
    logic emit_second;
    logic next_pair;
  } pfc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       code_ok;
    logic       key_ready;
    logic       walk_last;
    logic       has_pair;
    logic       more_pair;
    logic       out_free;
  } pfc_status_t;

endpackage

>>> rtl/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_ctrl: sequencer for the Playfair cipher
// Takes one word at a time, walks key fill and pair substitution steps.
// ----------------------------------------------------------------------------
module pfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  pfc_pkg::pfc_status_t status,
  output logic                 item_stall,
  output pfc_pkg::pfc_cmd_t    cmd
);
  import pfc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_POS    = 3'd3;
  localparam logic [2:0] S_CELL   = 3'd4;
  localparam logic [2:0] S_OUT0   = 3'd5;
  localparam logic [2:0] S_OUT1   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (status.op)
          OP_KEY_START: cmd.clear_key = 1'b1;
          OP_KEY_LETTER: cmd.place_item = !status.key_ready;
          OP_KEY_FINISH: begin
            cmd.fill_start = 1'b1;
            state_next     = S_FILL;
          end
          OP_ENCRYPT, OP_DECRYPT: begin
            if (status.key_ready && status.code_ok) begin
              cmd.plan = 1'b1;
              if (status.has_pair) state_next = S_POS;
            end
          end
          default: ;
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.walk_last) state_next = S_IDLE;
      end
      S_POS: begin
        cmd.read_pos = 1'b1;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.read_cell = 1'b1;
        state_next    = S_OUT0;
      end
      S_OUT0: begin
        if (status.out_free) begin
          cmd.emit_first = 1'b1;
          state_next     = S_OUT1;
        end
      end
      S_OUT1: begin
        if (status.out_free) begin
          cmd.emit_second = 1'b1;
          if (status.more_pair) begin
            cmd.next_pair = 1'b1;
            state_next    = S_POS;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

`ifndef SYNTHESIS
  // a substitution always runs position read, then cell read
  a_pos_then_cell: assert property (@(posedge clk) disable iff (rst)
    cmd.read_pos |=> cmd.read_cell)
    else $error("cell read did not follow position read");

  // a word is taken only while idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> (state == S_DECODE))
    else $error("load outside idle");

  // the first letter of a pair is not followed directly by a position read or a word load
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_first |=> !cmd.read_pos && !cmd.load_item)
    else $error("emit order broken");
`endif

endmodule

>>> rtl/pfc_datapath.sv
// ----------------------------------------------------------------------------
// pfc_datapath: key square, letter positions, pairing state and output word
// Holds the square memories and performs one substitution step per command.
// ----------------------------------------------------------------------------
module pfc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  pfc_pkg::pfc_cmd_t    cmd,
  input  logic [2:0]           op,
  input  logic [4:0]           letter,
  input  logic                 final_letter,
  input  logic                 result_stall,
  output pfc_pkg::pfc_status_t status,
  output logic                 result_valid,
  output logic [4:0]           out_letter,
  output logic                 run_end,
  output logic                 message_end
);
  import pfc_pkg::*;

  // row/col split of a cell index 0..24
  function automatic logic [2:0] row_of(input logic [4:0] pos);
    logic [2:0] r;
    if (pos >= 5'd20)      r = 3'd4;
    else if (pos >= 5'd15) r = 3'd3;
    else if (pos >= 5'd10) r = 3'd2;
    else if (pos >= 5'd5)  r = 3'd1;
    else                   r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] pos);
    logic [2:0] r;
    r = row_of(pos);
    return 3'(pos - cell_of(r, 3'd0));
  endfunction

  function automatic logic [2:0] step5(input logic [2:0] v, input logic fwd);
    logic [2:0] s;
    if (fwd) s = (v == 3'd4) ? 3'd0 : v + 3'd1;
    else     s = (v == 3'd0) ? 3'd4 : v - 3'd1;
    return s;
  endfunction

  function automatic logic [4:0] filler(input logic [4:0] code);
    return (code == CODE_X) ? CODE_Y : CODE_X;
  endfunction

  // item
  logic [2:0] item_op;
  logic [4:0] item_code;
  logic       item_fin;

  // key state
  logic [4:0]         key_square [CELLS];
  logic [4:0]         letter_position [LETTERS];
  logic [LETTERS-1:0] used;
  logic [4:0]         fill_count;
  logic               key_ready;
  logic [4:0]         walk_code;

  // stream state
  logic [4:0] prev_letter;
  logic       prev_valid;
  logic [4:0] pending_letter;
  logic       pending_valid;

  // pair in flight
  logic [4:0] pair_a;
  logic [4:0] pair_b;
  logic       pair_enc;
  logic       more_pair;
  logic [4:0] pa;
  logic [4:0] pb;
  logic [4:0] qa;
  logic [4:0] qb;

  // place step
  logic [4:0] place_code;
  logic       place_en;

  assign place_code = cmd.fill_step ? walk_code : item_code;
  assign place_en   = (cmd.place_item || (cmd.fill_step && walk_code != CODE_J))
                      && (place_code <= CODE_Z) && !used[place_code]
                      && (fill_count < SQUARE_FULL);

  // pair planning for a stream letter
  logic       enc;
  logic       dup;
  logic [4:0] fcode;
  logic       plan_has_pair;
  logic       plan_second;
  logic [4:0] plan_a;
  logic [4:0] plan_b;
  logic       pending_valid_next;

  always_comb begin
    enc   = (item_op == OP_ENCRYPT);
    dup   = prev_valid && (prev_letter == item_code);
    fcode = filler(item_code);
    plan_second = 1'b0;
    if (enc) begin
      plan_has_pair      = dup || pending_valid || item_fin;
      plan_second        = dup && pending_valid && item_fin;
      pending_valid_next = !item_fin && (dup == pending_valid);
      if (dup && pending_valid) begin
        plan_a = pending_letter;
        plan_b = fcode;
      end else if (dup) begin
        plan_a = fcode;
        plan_b = item_code;
      end else if (pending_valid) begin
        plan_a = pending_letter;
        plan_b = item_code;
      end else begin
        plan_a = item_code;
        plan_b = fcode;
      end
    end else begin
      plan_has_pair      = pending_valid;
      pending_valid_next = !item_fin && !pending_valid;
      plan_a             = pending_letter;
      plan_b             = item_code;
    end
  end

  // item and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= '0;
      fill_count     <= '0;
      key_ready      <= 1'b0;
      prev_letter    <= '0;
      prev_valid     <= 1'b0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
      more_pair      <= 1'b0;
    end else begin
      if (cmd.clear_key) begin
        used          <= '0;
        fill_count    <= '0;
        key_ready     <= 1'b0;
        prev_valid    <= 1'b0;
        pending_valid <= 1'b0;
      end
      if (place_en) begin
        used[place_code] <= 1'b1;
        fill_count       <= fill_count + 5'd1;
      end
      if (cmd.fill_step && walk_code == CODE_Z) key_ready <= 1'b1;
      if (cmd.plan) begin
        pending_valid <= pending_valid_next;
        if (pending_valid_next) pending_letter <= item_code;
        if (enc) begin
          prev_letter <= item_code;
          prev_valid  <= !item_fin;
        end else if (item_fin) begin
          prev_valid <= 1'b0;
        end
        more_pair <= plan_second;
      end
      if (cmd.next_pair) more_pair <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= op;
      item_code <= (letter == CODE_J) ? CODE_I : letter;
      item_fin  <= final_letter;
    end
    if (cmd.fill_start) walk_code <= '0;
    else if (cmd.fill_step) walk_code <= walk_code + 5'd1;
    if (cmd.plan) begin
      pair_a   <= plan_a;
      pair_b   <= plan_b;
      pair_enc <= enc;
    end else if (cmd.next_pair) begin
      pair_a <= item_code;
      pair_b <= fcode;
    end
  end

  // letter position memory
  always_ff @(posedge clk) begin
    if (place_en) letter_position[place_code] <= fill_count;
    if (cmd.read_pos) begin
      pa <= letter_position[pair_a];
      pb <= letter_position[pair_b];
    end
  end

  // substitution cells
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] cell_a, cell_b;

  always_comb begin
    ra = row_of(pa);
    ca = col_of(pa);
    rb = row_of(pb);
    cb = col_of(pb);
    if (ra == rb) begin
      cell_a = cell_of(ra, step5(ca, pair_enc));
      cell_b = cell_of(rb, step5(cb, pair_enc));
    end else if (ca == cb) begin
      cell_a = cell_of(step5(ra, pair_enc), ca);
      cell_b = cell_of(step5(rb, pair_enc), cb);
    end else begin
      cell_a = cell_of(ra, cb);
      cell_b = cell_of(rb, ca);
    end
  end

  // key square memory
  always_ff @(posedge clk) begin
    if (place_en) key_square[fill_count] <= place_code;
    if (cmd.read_cell) begin
      qa <= key_square[cell_a];
      qb <= key_square[cell_b];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_first || cmd.emit_second) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      out_letter  <= qa;
      run_end     <= 1'b0;
      message_end <= 1'b0;
    end else if (cmd.emit_second) begin
      out_letter  <= qb;
      run_end     <= !more_pair;
      message_end <= !more_pair && item_fin;
    end
  end

  always_comb begin
    status.op        = item_op;
    status.code_ok   = (item_code <= CODE_Z);
    status.key_ready = key_ready;
    status.walk_last = (walk_code == CODE_Z);
    status.has_pair  = plan_has_pair;
    status.more_pair = more_pair;
    status.out_free  = !result_valid || !result_stall;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= SQUARE_FULL)
    else $error("fill count past square size");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    key_ready |-> (fill_count == SQUARE_FULL))
    else $error("square ready but not full");

  a_pending_ready: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> key_ready)
    else $error("open pair without a ready square");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_first || cmd.emit_second) |-> (!result_valid || !result_stall))
    else $error("output word overwritten while stalled");
`endif

endmodule

>>> rtl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: Playfair 5x5 key square build, encrypt and decrypt
// Key start/letter words are applied at decode; key finish walks all 26 letter
// codes to fill the square. A stream letter completes no pair, one pair or two,
// and waits on result stall; each square memory reads both pair addresses in the
// same cycle; the output register holds one letter at a time. The first letter
// passes decode, position and cell reads. Sync reset clears key and pairing state.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] op,
  input  logic [4:0] letter,
  input  logic       final_letter,
  // result words
  output logic       result_valid,
  input  logic       result_stall,
  output logic [4:0] out_letter,
  output logic       run_end,
  output logic       message_end
);
  import pfc_pkg::*;

  // Controller and datapath talk only through these two bundles.
  pfc_cmd_t    cmd;
  pfc_status_t status;

  // Sequencer: idle -> decode -> (fill walk | position read -> cell read ->
  // two output letters, repeated once when a padded pair follows).
  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // Square memories, pairing state and the registered output word. The
  // output register lets a finished letter wait while the next pair reads.
  pfc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op           (op),
    .letter       (letter),
    .final_letter (final_letter),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .out_letter   (out_letter),
    .run_end      (run_end),
    .message_end  (message_end)
  );

endmodule
